// ----- sv/cqm_pkg.sv -----
// Shared constants, payload types and helpers for the completion queue manager.
`default_nettype none

package cqm_pkg;

    localparam int NUM_QUEUES = 16;
    localparam int MAX_DEPTH  = 64;
    localparam int WORD_WIDTH = 64;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int QID_W   = 8;
    localparam int DEPTH_W = 7;
    localparam int CW_W    = 64;
    localparam int LIM_W   = 7;
    localparam int STAT_W  = 2;
    localparam int GQ_W    = 5;

    // derived widths
    localparam int Q_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int CNT_W   = $clog2(NUM_QUEUES + 1);
    localparam int IDX_W   = $clog2(MAX_DEPTH);
    localparam int SZ_W    = $clog2(MAX_DEPTH + 1);
    localparam int N_W     = $clog2(MAX_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_QUEUES * MAX_DEPTH;
    localparam int ADDR_W  = $clog2(RAM_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_POLL   = 2'd2,
        CMD_RSVD   = 2'd3
    } t_cmd;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [QID_W-1:0]   queue_id;
        logic [DEPTH_W-1:0] ring_depth;
        logic [CW_W-1:0]    completion_word;
        logic [LIM_W-1:0]   poll_limit;
    } t_cqm_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [GQ_W-1:0]   granted_queue;
        logic [CW_W-1:0]   popped_word;
        logic              word_valid;
        logic              last_flag;
    } t_cqm_out;

    // result of the ring pointer step unit
    typedef struct packed {
        logic [IDX_W-1:0] nxt;
        logic             hit;
    } t_step_res;

    function automatic logic [ADDR_W-1:0] ram_addr(input logic [Q_W-1:0] q,
                                                   input logic [IDX_W-1:0] idx);
        ram_addr = ADDR_W'(q) * ADDR_W'(MAX_DEPTH) + ADDR_W'(idx);
    endfunction

endpackage

`default_nettype wire

// ----- sv/cqm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module cqm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/cqm_step.sv -----
// Ring pointer step unit: next slot modulo ring size and compare with the other pointer.
`default_nettype none

module cqm_step (
    input  wire logic [cqm_pkg::IDX_W-1:0] i_idx,
    input  wire logic [cqm_pkg::SZ_W-1:0]  i_size,
    input  wire logic [cqm_pkg::IDX_W-1:0] i_cmp,
    output cqm_pkg::t_step_res             o_res
);
    import cqm_pkg::*;

    logic [SZ_W-1:0] inc;

    always_comb begin
        inc = SZ_W'(i_idx) + SZ_W'(1);
        // wrap when the incremented index reaches the ring size
        o_res.nxt = (inc == i_size) ? '0 : IDX_W'(inc);
        o_res.hit = (o_res.nxt == i_cmp);
    end

endmodule

`default_nettype wire

// ----- sv/completion_queue_manager_top.sv -----
// Completion queue manager: command sequencer, queue pointer tables and entry RAM.
//
// One request channel (i_in_valid / o_in_stall / i_in_data) and one result
// channel (o_out_valid / i_out_stall / o_out_data). A request is taken when
// valid is high and stall is low; the block then stalls its input until the
// last result of that request has been loaded into the output register.
// A create, a push, a request with a bad argument or an unknown queue, and
// a poll of an empty queue give one result: the sequencer computes it from
// the registered request, then loads it into the output register. Any other
// poll gives one result per popped word, each word taking an entry RAM read,
// then a load of the output register.
// The single read port of the entry RAM and the shared pointer step unit
// set the pace of a poll. If the receiver stalls, the result holds in the
// output register and the sequencer waits until it is taken.
// Synchronous reset empties every queue (no queue exists after reset) and
// clears the output; the entry RAM is not cleared, as only written slots
// are ever read. Queues are handed out in ascending order and never freed.
`default_nettype none

module completion_queue_manager_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire cqm_pkg::t_cqm_in i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output cqm_pkg::t_cqm_out     o_out_data
);
    import cqm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT,
        S_POP_RD,
        S_POP_WAIT
    } t_state;

    t_state           r_state;
    t_cqm_in          r_item;
    t_cqm_out         r_res;
    t_cqm_out         r_out;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [N_W-1:0]   r_n;
    logic             r_last;
    logic [SZ_W-1:0]  r_size [NUM_QUEUES];
    logic [IDX_W-1:0] r_rd   [NUM_QUEUES];
    logic [IDX_W-1:0] r_wr   [NUM_QUEUES];

    logic              out_free;
    logic              out_load;
    logic              qid_ok;
    logic              found;
    logic              depth_ok;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    q_new;
    logic [SZ_W-1:0]   q_size;
    logic [IDX_W-1:0]  q_rd;
    logic [IDX_W-1:0]  q_wr;
    logic [IDX_W-1:0]  step_idx;
    logic [IDX_W-1:0]  step_cmp;
    t_step_res         step;
    logic              do_create;
    logic              do_push;
    logic              go_pop;
    logic [STAT_W-1:0] res_status;
    logic [GQ_W-1:0]   res_granted;
    logic [N_W-1:0]    n_n;
    logic              n_last;
    logic              ram_re;
    logic [WORD_WIDTH-1:0] ram_rdata;

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = ((r_state == S_EMIT) || (r_state == S_POP_WAIT)) && out_free;

    // request decode and table lookup
    always_comb begin
        qid_ok   = (r_item.queue_id != '0)
                   && ((QID_W+1)'(r_item.queue_id) <= (QID_W+1)'(NUM_QUEUES));
        found    = (QID_W+1)'(r_item.queue_id) <= (QID_W+1)'(r_count);
        depth_ok = (r_item.ring_depth != '0)
                   && (r_item.ring_depth <= DEPTH_W'(MAX_DEPTH));
        q        = Q_W'(r_item.queue_id - QID_W'(1));
        q_new    = Q_W'(r_count);
        q_size   = r_size[q];
        q_rd     = r_rd[q];
        q_wr     = r_wr[q];
    end

    // push steps the write pointer against the read pointer, pop the reverse
    assign step_idx = (r_state == S_POP_RD) ? q_rd : q_wr;
    assign step_cmp = (r_state == S_POP_RD) ? q_wr : q_rd;

    cqm_step u_step (
        .i_idx  (step_idx),
        .i_size (q_size),
        .i_cmp  (step_cmp),
        .o_res  (step)
    );

    always_comb begin
        do_create   = 1'b0;
        do_push     = 1'b0;
        go_pop      = 1'b0;
        res_status  = ST_INVALID;
        res_granted = '0;
        case (t_cmd'(r_item.cmd))
            CMD_CREATE: begin
                if (!depth_ok) begin
                    res_status = ST_INVALID;
                end else if (r_count == CNT_W'(NUM_QUEUES)) begin
                    res_status = ST_FULL;
                end else begin
                    res_status  = ST_OK;
                    res_granted = GQ_W'(r_count + CNT_W'(1));
                    do_create   = 1'b1;
                end
            end
            CMD_PUSH: begin
                if (!qid_ok) begin
                    res_status = ST_INVALID;
                end else if (!found) begin
                    res_status = ST_NOT_FOUND;
                end else if (step.hit) begin
                    res_status = ST_FULL;
                end else begin
                    res_status = ST_OK;
                    do_push    = 1'b1;
                end
            end
            CMD_POLL: begin
                if (r_item.poll_limit == '0 || !qid_ok) begin
                    res_status = ST_INVALID;
                end else if (!found) begin
                    res_status = ST_NOT_FOUND;
                end else begin
                    res_status = ST_OK;
                    go_pop     = (q_rd != q_wr);
                end
            end
            default: begin
                res_status = ST_INVALID;
            end
        endcase
    end

    // pop bookkeeping: the word just read is the last one when the limit,
    // MAX_DEPTH words or the write pointer is reached
    always_comb begin
        n_n    = r_n + N_W'(1);
        n_last = (LIM_W'(n_n) == r_item.poll_limit)
                 || (n_n == N_W'(MAX_DEPTH)) || step.hit;
    end

    assign ram_re = (r_state == S_POP_RD);

    cqm_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_EXEC) && do_push),
        .i_waddr (ram_addr(q, q_wr)),
        .i_wdata (WORD_WIDTH'(r_item.completion_word)),
        .i_re    (ram_re),
        .i_raddr (ram_addr(q, q_rd)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out       <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_n         <= '0;
            r_last      <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_size[i] <= '0;
                r_rd[i]   <= '0;
                r_wr[i]   <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res.status        <= res_status;
                    r_res.granted_queue <= res_granted;
                    r_res.popped_word   <= '0;
                    r_res.word_valid    <= 1'b0;
                    r_res.last_flag     <= 1'b1;
                    r_n                 <= '0;
                    if (do_create) begin
                        r_size[q_new] <= SZ_W'(r_item.ring_depth);
                        r_count       <= r_count + CNT_W'(1);
                    end
                    if (do_push) begin
                        r_wr[q] <= step.nxt;
                    end
                    r_state <= go_pop ? S_POP_RD : S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                S_POP_RD: begin
                    r_rd[q] <= step.nxt;
                    r_n     <= n_n;
                    r_last  <= n_last;
                    r_state <= S_POP_WAIT;
                end
                S_POP_WAIT: begin
                    if (out_free) begin
                        r_out.status        <= ST_OK;
                        r_out.granted_queue <= '0;
                        r_out.popped_word   <= CW_W'(ram_rdata);
                        r_out.word_valid    <= 1'b1;
                        r_out.last_flag     <= r_last;
                        r_state             <= r_last ? S_IDLE : S_POP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_word_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.word_valid |-> o_out_data.status == ST_OK)
        else $error("popped word with non-ok status");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK
        |-> o_out_data.last_flag && !o_out_data.word_valid
            && o_out_data.granted_queue == '0)
        else $error("error result not a lone last result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(NUM_QUEUES))
        else $error("queue count beyond table size");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP_RD |=> r_state == S_POP_WAIT)
        else $error("entry read not followed by result load");

endmodule

`default_nettype wire
